// ----- src/fcm_pkg.sv -----
// Package for the freshness counter manager.
// Holds command codes, field widths, the stage record and the mask and bit length helpers.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package fcm_pkg;

	// Field widths of the words on the two channels.
	localparam int CMD_W = 3;
	localparam int ID_W  = 4;
	localparam int VAL_W = 64;
	localparam int LEN_W = 7;

	// Defaults for the top level parameters.
	localparam int NUM_IDS_DEF = 16;
	localparam int FV_BITS_DEF = 64;

	// Bits per byte, used for whole-byte rounding.
	localparam int BYTE_BITS = 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INC  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UPD  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TX   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TXT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RX   = 3'd4;

	// Record handed from the execute stage to the finish stage.
	typedef struct packed {
		logic             err;
		logic             wr_en;
		logic [CMD_W-1:0] cmd;
		logic [VAL_W-1:0] value;
		logic [LEN_W-1:0] len;
		logic [VAL_W-1:0] tv;
		logic [VAL_W-1:0] ctr;
	} exec_t;

	// Mask of the low n bits, all ones from 64 upward.
	function automatic logic [VAL_W-1:0] low_mask(input logic [LEN_W-1:0] n);
		logic [VAL_W-1:0] m;
		if (n >= LEN_W'(VAL_W)) begin
			m = '1;
		end else begin
			m = (VAL_W'(1) << n) - VAL_W'(1);
		end
		return m;
	endfunction

	// Mask covering ceil(n/8) whole bytes.
	function automatic logic [VAL_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [LEN_W:0] r;
		r = ({1'b0, n} + (LEN_W+1)'(BYTE_BITS - 1)) & ~((LEN_W+1)'(BYTE_BITS - 1));
		return low_mask((r > (LEN_W+1)'(VAL_W)) ? LEN_W'(VAL_W) : r[LEN_W-1:0]);
	endfunction

	// Position of the highest set bit, zero for zero.
	function automatic logic [LEN_W-1:0] bit_len(input logic [VAL_W-1:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < VAL_W; i++) begin
			if (v[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ----- src/fcm_table.sv -----
// Counter table of the freshness counter manager: one synchronous memory.
// One write port, one read port with registered data, and a clearing pass after reset.
// Depends on fcm_pkg.
`timescale 1ns / 1ps

module fcm_table #(
	parameter int NUM_IDS = fcm_pkg::NUM_IDS_DEF,
	parameter int FV_BITS = fcm_pkg::FV_BITS_DEF,
	localparam int IDX_W  = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_idx,
	output logic [FV_BITS-1:0] rd_data,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [FV_BITS-1:0] wr_data,
	output logic               busy
);

	logic [FV_BITS-1:0] mem [NUM_IDS];
	logic [FV_BITS-1:0] rd_data_q;
	logic               clr_busy_q;
	logic [IDX_W-1:0]   clr_idx_q;

	// Clearing pass: one entry per cycle from reset until the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(NUM_IDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + IDX_W'(1);
		end
	end

	// Write port, shared by the clearing pass and the write-back.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

// ----- src/fcm_alu.sv -----
// Execute stage logic of the freshness counter manager.
// Builds the new counter, the tx words or the rebuilt rx value from the counter read.
// Depends on fcm_pkg.
`timescale 1ns / 1ps

module fcm_alu #(
	parameter int FV_BITS = fcm_pkg::FV_BITS_DEF
) (
	input  logic [fcm_pkg::CMD_W-1:0] cmd,
	input  logic                      err,
	input  logic [fcm_pkg::VAL_W-1:0] ctr_in,
	input  logic [fcm_pkg::VAL_W-1:0] value_in,
	input  logic [fcm_pkg::LEN_W-1:0] req_len,
	input  logic [fcm_pkg::LEN_W-1:0] trunc_len,
	output fcm_pkg::exec_t            res
);

	localparam logic [fcm_pkg::VAL_W-1:0] FV_MASK =
		fcm_pkg::low_mask(fcm_pkg::LEN_W'(FV_BITS));

	logic [fcm_pkg::VAL_W-1:0] ctr;
	logic [fcm_pkg::VAL_W-1:0] upd_m;
	logic [fcm_pkg::LEN_W-1:0] ctr_len;
	logic [fcm_pkg::LEN_W-1:0] tx_len;
	logic [fcm_pkg::VAL_W-1:0] tx_bm;
	logic [fcm_pkg::VAL_W-1:0] tx_fv;
	logic [fcm_pkg::VAL_W-1:0] rx_m;
	logic [fcm_pkg::VAL_W-1:0] rx_rl;
	logic [fcm_pkg::VAL_W-1:0] rx_upper;
	logic [fcm_pkg::VAL_W-1:0] rx_bumped;
	logic [fcm_pkg::VAL_W-1:0] rebuilt;

	assign ctr = ctr_in & FV_MASK;

	// Update merges the low whole bytes of the new word.
	assign upd_m = fcm_pkg::byte_mask(req_len) & FV_MASK;

	// Tx read length is the smaller of the request and the counter length.
	assign ctr_len = fcm_pkg::bit_len(ctr);
	assign tx_len  = (req_len <= ctr_len) ? req_len : ctr_len;
	assign tx_bm   = fcm_pkg::byte_mask(tx_len);
	assign tx_fv   = ctr & tx_bm;

	// Rx rebuild from the received low bits; the upper part steps on when they do not exceed.
	assign rx_m      = fcm_pkg::low_mask(trunc_len);
	assign rx_rl     = value_in & rx_m;
	assign rx_upper  = ctr & ~rx_m;
	assign rx_bumped = (rx_upper + (fcm_pkg::VAL_W'(1) << trunc_len)) & FV_MASK;

	always_comb begin
		if (trunc_len == fcm_pkg::LEN_W'(FV_BITS)) begin
			rebuilt = value_in & FV_MASK;
		end else if (rx_rl > (ctr & rx_m)) begin
			rebuilt = rx_upper | rx_rl;
		end else begin
			rebuilt = rx_bumped | rx_rl;
		end
	end

	// Select the word that goes to the finish stage.
	always_comb begin
		res       = '0;
		res.err   = err;
		res.cmd   = cmd;
		res.ctr   = ctr;
		if (!err) begin
			unique case (cmd)
				fcm_pkg::CMD_INC: begin
					res.value = (ctr + fcm_pkg::VAL_W'(1)) & FV_MASK;
					res.wr_en = 1'b1;
				end
				fcm_pkg::CMD_UPD: begin
					res.value = (ctr & ~upd_m) | (value_in & upd_m);
					res.wr_en = 1'b1;
				end
				fcm_pkg::CMD_TX: begin
					res.value = tx_fv;
					res.len   = tx_len;
				end
				fcm_pkg::CMD_TXT: begin
					res.value = tx_fv;
					res.len   = tx_len;
					res.tv    = tx_fv & fcm_pkg::low_mask(trunc_len) & tx_bm;
				end
				default: begin
					res.value = rebuilt;
				end
			endcase
		end
	end

endmodule

// ----- src/freshness_counter_manager_core.sv -----
// Top level of the freshness counter manager.
// Holds the command sequencer, the finish stage and the output register; uses fcm_table and fcm_alu.
// Depends on fcm_pkg.
`timescale 1ns / 1ps

// The block keeps one freshness counter per id in a small synchronous memory and runs one
// command per word: increment, update, tx read, tx truncated read or rx verify, each giving
// exactly one result word. The memory read comes in the cycle the word is accepted, then
// an execute cycle, then a finish cycle that writes the counter back and loads the output
// register while the next word is already accepted; the finish waits while out_stall holds
// a full output register. A counter written back is forwarded to a read of the same id. The
// read-modify-write loop through the table means no word is accepted before the last one finishes.
// After reset the table is cleared one entry per cycle, and in_stall stays high until that pass is
// done. Lengths above FV_BITS on any command but increment, unknown commands and ids at or above
// NUM_IDS give status 1 with all other fields zero and leave the table as it was.
module freshness_counter_manager_core #(
	parameter int NUM_IDS = fcm_pkg::NUM_IDS_DEF,
	parameter int FV_BITS = fcm_pkg::FV_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [fcm_pkg::CMD_W-1:0] cmd,
	input  logic [fcm_pkg::ID_W-1:0]  id,
	input  logic [fcm_pkg::VAL_W-1:0] value_in,
	input  logic [fcm_pkg::LEN_W-1:0] req_len,
	input  logic [fcm_pkg::LEN_W-1:0] trunc_len,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic [fcm_pkg::VAL_W-1:0] fresh_value,
	output logic [fcm_pkg::LEN_W-1:0] fresh_len,
	output logic [fcm_pkg::VAL_W-1:0] trunc_value,
	output logic [fcm_pkg::LEN_W-1:0] trunc_len_out
);

	localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]                state_q;
	logic                      tbl_busy;
	logic                      fin_go;
	logic                      accept;
	logic                      err_in;
	logic [IDX_W-1:0]          idx_in;
	logic [FV_BITS-1:0]        rd_data;

	logic [fcm_pkg::CMD_W-1:0] cmd_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic [fcm_pkg::VAL_W-1:0] vin_s1;
	logic [fcm_pkg::LEN_W-1:0] rlen_s1;
	logic [fcm_pkg::LEN_W-1:0] tlen_s1;
	logic                      err_s1;
	logic                      fwd_s1;
	logic [FV_BITS-1:0]        fwd_data_s1;
	logic [fcm_pkg::VAL_W-1:0] ctr_s1;
	fcm_pkg::exec_t            exec_res;

	fcm_pkg::exec_t            ex_s2;
	logic [IDX_W-1:0]          idx_s2;

	logic                      fin_status;
	logic [fcm_pkg::LEN_W-1:0] fin_flen;
	logic [fcm_pkg::LEN_W-1:0] fin_tlen;

	logic                      out_valid_q;
	logic                      status_q;
	logic [fcm_pkg::VAL_W-1:0] fresh_value_q;
	logic [fcm_pkg::LEN_W-1:0] fresh_len_q;
	logic [fcm_pkg::VAL_W-1:0] trunc_value_q;
	logic [fcm_pkg::LEN_W-1:0] trunc_len_q;

	// The finish stage completes once the output register is free or being emptied.
	assign fin_go   = (state_q == ST_FIN) && !(out_valid_q && out_stall);
	assign in_stall = tbl_busy || !((state_q == ST_IDLE) || fin_go);
	assign accept   = in_valid && !in_stall;

	// Error checks on the incoming word.
	assign idx_in = IDX_W'(id);
	assign err_in = (32'(id) >= NUM_IDS) || (cmd > fcm_pkg::CMD_RX) ||
		((cmd != fcm_pkg::CMD_INC) &&
		 ((req_len > fcm_pkg::LEN_W'(FV_BITS)) || (trunc_len > fcm_pkg::LEN_W'(FV_BITS))));

	// Sequencer: accept and read, execute, finish.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= accept ? ST_EXEC : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	fcm_table #(
		.NUM_IDS (NUM_IDS),
		.FV_BITS (FV_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (idx_in),
		.rd_data (rd_data),
		.wr_en   (fin_go && ex_s2.wr_en),
		.wr_idx  (idx_s2),
		.wr_data (ex_s2.value[FV_BITS-1:0]),
		.busy    (tbl_busy)
	);

	// Capture the accepted word, and forward a write-back to the same entry.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd;
			idx_s1      <= idx_in;
			vin_s1      <= value_in;
			rlen_s1     <= req_len;
			tlen_s1     <= trunc_len;
			err_s1      <= err_in;
			fwd_s1      <= fin_go && ex_s2.wr_en && (idx_s2 == idx_in);
			fwd_data_s1 <= ex_s2.value[FV_BITS-1:0];
		end
	end

	assign ctr_s1 = fcm_pkg::VAL_W'(fwd_s1 ? fwd_data_s1 : rd_data);

	fcm_alu #(
		.FV_BITS (FV_BITS)
	) u_alu (
		.cmd       (cmd_s1),
		.err       (err_s1),
		.ctr_in    (ctr_s1),
		.value_in  (vin_s1),
		.req_len   (rlen_s1),
		.trunc_len (tlen_s1),
		.res       (exec_res)
	);

	// Execute stage register.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			ex_s2  <= exec_res;
			idx_s2 <= idx_s1;
		end
	end

	// Finish stage: bit lengths and the rx freshness check.
	always_comb begin
		fin_status = ex_s2.err;
		fin_flen   = '0;
		fin_tlen   = '0;
		if (!ex_s2.err) begin
			if ((ex_s2.cmd == fcm_pkg::CMD_TX) || (ex_s2.cmd == fcm_pkg::CMD_TXT)) begin
				fin_flen = ex_s2.len;
			end else begin
				fin_flen = fcm_pkg::bit_len(ex_s2.value);
			end
			if (ex_s2.cmd == fcm_pkg::CMD_TXT) begin
				fin_tlen = fcm_pkg::bit_len(ex_s2.tv);
			end
			if (ex_s2.cmd == fcm_pkg::CMD_RX) begin
				fin_status = !(ex_s2.value > ex_s2.ctr);
			end
		end
	end

	// Output register: holds one result word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q      <= fin_status;
			fresh_value_q <= ex_s2.err ? '0 : ex_s2.value;
			fresh_len_q   <= fin_flen;
			trunc_value_q <= ex_s2.err ? '0 : ex_s2.tv;
			trunc_len_q   <= fin_tlen;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign fresh_value   = fresh_value_q;
	assign fresh_len     = fresh_len_q;
	assign trunc_value   = trunc_value_q;
	assign trunc_len_out = trunc_len_q;

endmodule

// ----- test/freshness_counter_manager_core_tb.sv -----
// Testbench for freshness_counter_manager_core: directed table, then random command words.
// Predicts every result word in its own counter table and compares field by field.
// Depends on fcm_pkg and the freshness_counter_manager_core RTL.
`timescale 1ns / 1ps

module freshness_counter_manager_core_tb;

	localparam int NUM_IDS      = fcm_pkg::NUM_IDS_DEF;
	localparam int FV_BITS      = fcm_pkg::FV_BITS_DEF;
	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_WORDS = 1080;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// Command codes the block does not know.
	localparam logic [fcm_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [fcm_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	localparam logic [fcm_pkg::VAL_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [fcm_pkg::CMD_W-1:0] cmd;
		logic [fcm_pkg::ID_W-1:0]  id;
		logic [fcm_pkg::VAL_W-1:0] vin;
		logic [fcm_pkg::LEN_W-1:0] rlen;
		logic [fcm_pkg::LEN_W-1:0] tlen;
	} fcm_word_t;

	typedef struct packed {
		logic                      st;
		logic [fcm_pkg::VAL_W-1:0] fv;
		logic [fcm_pkg::LEN_W-1:0] flen;
		logic [fcm_pkg::VAL_W-1:0] tv;
		logic [fcm_pkg::LEN_W-1:0] tl;
	} fresh_result_t;

	// One directed row: the command word, then a result typed in by hand if given is set.
	typedef struct packed {
		fcm_word_t     word;
		logic          given;
		fresh_result_t res;
	} plan_row_t;

	localparam fresh_result_t NO_RESULT = '0;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [fcm_pkg::CMD_W-1:0] cmd = '0;
	logic [fcm_pkg::ID_W-1:0]  id = '0;
	logic [fcm_pkg::VAL_W-1:0] value_in = '0;
	logic [fcm_pkg::LEN_W-1:0] req_len = '0;
	logic [fcm_pkg::LEN_W-1:0] trunc_len = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      status;
	logic [fcm_pkg::VAL_W-1:0] fresh_value;
	logic [fcm_pkg::LEN_W-1:0] fresh_len;
	logic [fcm_pkg::VAL_W-1:0] trunc_value;
	logic [fcm_pkg::LEN_W-1:0] trunc_len_out;

	logic [fcm_pkg::VAL_W-1:0] counters [NUM_IDS];
	fresh_result_t             expected_q [$];
	plan_row_t                 plan [$];
	int                        fail_count = 0;
	int                        cycle_count = 0;
	int                        send_idle_pct = 16;
	int                        recv_idle_pct = 68;
	int                        hold_reqs = 0;
	int                        hold_seen = 0;
	int                        hold_left = 0;

	freshness_counter_manager_core #(
		.NUM_IDS(NUM_IDS),
		.FV_BITS(FV_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.id(id),
		.value_in(value_in),
		.req_len(req_len),
		.trunc_len(trunc_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.fresh_value(fresh_value),
		.fresh_len(fresh_len),
		.trunc_value(trunc_value),
		.trunc_len_out(trunc_len_out)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Low n bits set; all bits from the full width upward.
	function automatic logic [fcm_pkg::VAL_W-1:0] ones_below(input int n);
		return (n >= fcm_pkg::VAL_W) ? ALL_ONES :
			((fcm_pkg::VAL_W'(1) << n) - fcm_pkg::VAL_W'(1));
	endfunction

	// Low bits up to the whole byte boundary at or above n bits.
	function automatic logic [fcm_pkg::VAL_W-1:0] bytes_covering(input int n);
		return ones_below(((n + 7) / 8) * 8);
	endfunction

	function automatic int highest_bit(input logic [fcm_pkg::VAL_W-1:0] v);
		for (int i = fcm_pkg::VAL_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				return i + 1;
			end
		end
		return 0;
	endfunction

	// Runs one accepted command word on the local counter table and returns its result.
	function automatic fresh_result_t apply_command(input fcm_word_t w);
		fresh_result_t             r;
		logic [fcm_pkg::VAL_W-1:0] fmask, ctr, m, rl, upper, rebuilt;
		int                        len;
		r = '0;
		r.st = ST_ERR;
		fmask = ones_below(FV_BITS);
		if (w.cmd > fcm_pkg::CMD_RX) begin
			return r;
		end
		if (w.cmd != fcm_pkg::CMD_INC && (w.rlen > FV_BITS || w.tlen > FV_BITS)) begin
			return r;
		end
		ctr = counters[w.id] & fmask;
		r.st = ST_OK;
		case (w.cmd)
			fcm_pkg::CMD_INC: begin
				ctr = (ctr + fcm_pkg::VAL_W'(1)) & fmask;
				counters[w.id] = ctr;
				r.fv = ctr;
				r.flen = fcm_pkg::LEN_W'(highest_bit(ctr));
			end
			fcm_pkg::CMD_UPD: begin
				m = bytes_covering(w.rlen) & fmask;
				ctr = (ctr & ~m) | (w.vin & m);
				counters[w.id] = ctr;
				r.fv = ctr;
				r.flen = fcm_pkg::LEN_W'(highest_bit(ctr));
			end
			fcm_pkg::CMD_TX, fcm_pkg::CMD_TXT: begin
				len = (w.rlen <= highest_bit(ctr)) ? int'(w.rlen) : highest_bit(ctr);
				m = bytes_covering(len);
				r.fv = ctr & m;
				r.flen = fcm_pkg::LEN_W'(len);
				if (w.cmd == fcm_pkg::CMD_TXT) begin
					r.tv = r.fv & ones_below(w.tlen) & m;
					r.tl = fcm_pkg::LEN_W'(highest_bit(r.tv));
				end
			end
			default: begin
				// Rebuild the full value from the received low bits.
				if (w.tlen == FV_BITS) begin
					rebuilt = w.vin & fmask;
				end else begin
					m = ones_below(w.tlen);
					rl = w.vin & m;
					upper = ctr & ~m;
					if (rl > (ctr & m)) begin
						rebuilt = upper | rl;
					end else begin
						rebuilt = ((upper + (fcm_pkg::VAL_W'(1) << w.tlen)) & fmask) | rl;
					end
				end
				r.fv = rebuilt;
				r.flen = fcm_pkg::LEN_W'(highest_bit(rebuilt));
				r.st = (rebuilt > ctr) ? ST_OK : ST_ERR;
			end
		endcase
		return r;
	endfunction

	// Lengths lean on zero and full width, with a few out of range.
	function automatic logic [fcm_pkg::LEN_W-1:0] random_len();
		int p;
		p = $urandom_range(99);
		if (p < 8) begin
			return '0;
		end else if (p < 16) begin
			return fcm_pkg::LEN_W'(FV_BITS);
		end else if (p < 22) begin
			return fcm_pkg::LEN_W'($urandom_range(127, FV_BITS + 1));
		end
		return fcm_pkg::LEN_W'($urandom_range(FV_BITS));
	endfunction

	// Random command word; values often sit close to the selected counter.
	function automatic fcm_word_t random_word();
		fcm_word_t                 w;
		int                        p;
		logic [fcm_pkg::VAL_W-1:0] ctr;
		p = $urandom_range(99);
		if (p < 14) begin
			w.cmd = fcm_pkg::CMD_INC;
		end else if (p < 30) begin
			w.cmd = fcm_pkg::CMD_UPD;
		end else if (p < 47) begin
			w.cmd = fcm_pkg::CMD_TX;
		end else if (p < 66) begin
			w.cmd = fcm_pkg::CMD_TXT;
		end else if (p < 95) begin
			w.cmd = fcm_pkg::CMD_RX;
		end else begin
			w.cmd = fcm_pkg::CMD_W'($urandom_range(CMD_RSVD7, CMD_RSVD5));
		end
		// Half of the words share a few ids so that back-to-back hits are common.
		if ($urandom_range(1) == 1) begin
			w.id = fcm_pkg::ID_W'($urandom_range(3));
		end else begin
			w.id = fcm_pkg::ID_W'($urandom_range(NUM_IDS - 1));
		end
		w.rlen = random_len();
		w.tlen = random_len();
		ctr = counters[w.id];
		case ($urandom_range(5))
			0: w.vin = '0;
			1: w.vin = ALL_ONES;
			2: w.vin = fcm_pkg::VAL_W'(1) << $urandom_range(fcm_pkg::VAL_W - 1);
			3, 4: w.vin = ctr + fcm_pkg::VAL_W'($urandom_range(2)) -
				fcm_pkg::VAL_W'($urandom_range(2));
			default: w.vin = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// Offers one word after a random gap and records its expected result on acceptance.
	task automatic send_word(input fcm_word_t w, input logic use_given, input fresh_result_t given);
		fresh_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= w.cmd;
		id <= w.id;
		value_in <= w.vin;
		req_len <= w.rlen;
		trunc_len <= w.tlen;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predicted = apply_command(w);
		expected_q.push_back(use_given ? given : predicted);
	endtask

	task automatic check_field(input string name, input logic [fcm_pkg::VAL_W-1:0] want,
			input logic [fcm_pkg::VAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Stimulus: reset, directed table, then three idling phases of random words.
	initial begin
		for (int i = 0; i < NUM_IDS; i++) begin
			counters[i] = '0;
		end

		// Columns: cmd, id, value_in, req_len, trunc_len, given, then the typed result.
		// Reads of the freshly cleared table.
		plan.push_back({fcm_pkg::CMD_TX, 4'd0, 64'h0, 7'd64, 7'd0,
			1'b1, ST_OK, 64'h0, 7'd0, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_TXT, 4'd15, ALL_ONES, 7'd64, 7'd64,
			1'b1, ST_OK, 64'h0, 7'd0, 64'h0, 7'd0});
		// Increment from zero; increment ignores even out-of-range lengths.
		plan.push_back({fcm_pkg::CMD_INC, 4'd0, 64'h0, 7'd0, 7'd0,
			1'b1, ST_OK, 64'h1, 7'd1, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_INC, 4'd0, 64'h0, 7'd127, 7'd127,
			1'b1, ST_OK, 64'h2, 7'd2, 64'h0, 7'd0});
		// Full-width update to all ones, then the increment wraps to zero.
		plan.push_back({fcm_pkg::CMD_UPD, 4'd1, ALL_ONES, 7'd64, 7'd0,
			1'b1, ST_OK, ALL_ONES, 7'd64, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_INC, 4'd1, 64'h0, 7'd0, 7'd0,
			1'b1, ST_OK, 64'h0, 7'd0, 64'h0, 7'd0});
		// Partial updates: 12 bits round up to two bytes, a zero length changes nothing.
		plan.push_back({fcm_pkg::CMD_UPD, 4'd2, 64'h0123_4567_89AB_CDEF, 7'd64, 7'd0,
			1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_UPD, 4'd2, 64'hFEDC_BA98_7654_3210, 7'd12, 7'd0,
			1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_UPD, 4'd2, ALL_ONES, 7'd0, 7'd0, 1'b0, NO_RESULT});
		// Tx reads cut by the request, by the truncation and by whole bytes.
		plan.push_back({fcm_pkg::CMD_TX, 4'd2, 64'h0, 7'd5, 7'd0, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_TXT, 4'd2, 64'h0, 7'd64, 7'd7, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_TXT, 4'd2, 64'h0, 7'd20, 7'd64, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_TXT, 4'd2, 64'h0, 7'd64, 7'd0, 1'b0, NO_RESULT});
		// Rx: zero truncation, full width fresh and stale, low bits ahead and behind.
		plan.push_back({fcm_pkg::CMD_RX, 4'd0, 64'h0, 7'd0, 7'd0, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_RX, 4'd2, ALL_ONES, 7'd0, 7'd64, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_RX, 4'd2, 64'h0, 7'd0, 7'd64, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_RX, 4'd2, 64'hFF, 7'd0, 7'd8, 1'b0, NO_RESULT});
		plan.push_back({fcm_pkg::CMD_RX, 4'd2, 64'h0, 7'd0, 7'd8, 1'b0, NO_RESULT});
		// Rx on an all-ones counter: the upper bits wrap and the value is stale.
		plan.push_back({fcm_pkg::CMD_UPD, 4'd3, ALL_ONES, 7'd64, 7'd0,
			1'b1, ST_OK, ALL_ONES, 7'd64, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_RX, 4'd3, 64'h0, 7'd0, 7'd4, 1'b0, NO_RESULT});
		// Error words: lengths above the counter width and unknown commands.
		plan.push_back({fcm_pkg::CMD_UPD, 4'd4, ALL_ONES, 7'd65, 7'd0,
			1'b1, ST_ERR, 64'h0, 7'd0, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_TX, 4'd4, 64'h0, 7'd127, 7'd0,
			1'b1, ST_ERR, 64'h0, 7'd0, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_TXT, 4'd4, 64'h0, 7'd64, 7'd65,
			1'b1, ST_ERR, 64'h0, 7'd0, 64'h0, 7'd0});
		plan.push_back({fcm_pkg::CMD_RX, 4'd4, ALL_ONES, 7'd0, 7'd127,
			1'b1, ST_ERR, 64'h0, 7'd0, 64'h0, 7'd0});
		plan.push_back({CMD_RSVD5, 4'd5, ALL_ONES, 7'd64, 7'd64,
			1'b1, ST_ERR, 64'h0, 7'd0, 64'h0, 7'd0});
		plan.push_back({CMD_RSVD7, 4'd6, 64'h0, 7'd0, 7'd0,
			1'b1, ST_ERR, 64'h0, 7'd0, 64'h0, 7'd0});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_word(plan[i].word, plan[i].given, plan[i].res);
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			// Between phases the sender pauses until every result word is back.
			if (n == RANDOM_WORDS / 3 || n == 2 * RANDOM_WORDS / 3) begin
				in_valid <= 1'b0;
				while (expected_q.size() != 0) begin
					@(posedge clk);
				end
				if (n == RANDOM_WORDS / 3) begin
					send_idle_pct = 68;
					recv_idle_pct = 16;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			end
			// Ask the receiver for a long hold-off while words keep coming.
			if (n == RANDOM_WORDS / 6 || n == 5 * RANDOM_WORDS / 6) begin
				hold_reqs <= hold_reqs + 1;
			end
			send_word(random_word(), 1'b0, NO_RESULT);
		end
		in_valid <= 1'b0;

		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Receiver: checks each accepted result word, then decides the next stall.
	always @(posedge clk) begin
		fresh_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result word with nothing expected, status %0d value %h",
					$time, status, fresh_value);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				check_field("status", fcm_pkg::VAL_W'(want.st), fcm_pkg::VAL_W'(status));
				check_field("fresh_value", want.fv, fresh_value);
				check_field("fresh_len", fcm_pkg::VAL_W'(want.flen),
					fcm_pkg::VAL_W'(fresh_len));
				check_field("trunc_value", want.tv, trunc_value);
				check_field("trunc_len_out", fcm_pkg::VAL_W'(want.tl),
					fcm_pkg::VAL_W'(trunc_len_out));
			end
		end
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule
